// ===== rtl/qdec_pkg.sv =====
// Shared types and constants for the quadrature decoder with speed unit.
// No dependencies; used by qdec_track, qdec_speed and the top level.
package qdec_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int COUNT_BITS_DEF = 16;
  localparam int SCALE_BITS     = 32;
  localparam int POS_BITS       = 16;
  localparam int SPEED_BITS     = 48;
  localparam int APB_ADDR_BITS  = 3;

  // mode field codes
  localparam logic MODE_PINS  = 1'b0;
  localparam logic MODE_SPEED = 1'b1;

  // register index (paddr[2])
  localparam logic REG_SPEED_SCALE = 1'b0;

  localparam logic [63:0] SPEED_POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] SPEED_NEG_MAG = 64'h0000_8000_0000_0000;

  // per-item side info carried along the speed pipeline
  typedef struct packed {
    logic [POS_BITS-1:0] position;
    logic                forward;
    logic                speed_valid;
  } qdec_tag_t;

endpackage

// ===== rtl/qdec_track.sv =====
// Per-channel edge tracking, position count and snapshot; first pipeline stage.
// Depends on qdec_pkg.
module qdec_track #(
  parameter int CHANNELS   = qdec_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = qdec_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  logic [1:0]            channel,
  input  logic                  pin_a,
  input  logic                  pin_b,
  output logic                  st_valid,
  input  logic                  st_ready,
  output qdec_pkg::qdec_tag_t   st_tag,
  output logic [COUNT_BITS-1:0] st_diff
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                  last_a         [CHANNELS];
  logic                  last_b         [CHANNELS];
  logic [COUNT_BITS-1:0] position_count [CHANNELS];
  logic                  direction      [CHANNELS];
  logic [COUNT_BITS-1:0] snapshot_count [CHANNELS];

  logic                  accept;
  logic                  ch_ok;
  logic [IW-1:0]         idx;
  logic                  cur_a, cur_b, cur_dir;
  logic [COUNT_BITS-1:0] cur_pos, cur_snap;
  logic                  a_chg, b_chg;
  logic                  dir_next;
  logic [COUNT_BITS-1:0] pos_next;
  logic [COUNT_BITS-1:0] diff;

  assign in_ready = !st_valid || st_ready;
  assign accept   = in_valid && in_ready;

  assign ch_ok = (32'(channel) < 32'(CHANNELS));
  assign idx   = ch_ok ? IW'(channel) : '0;

  assign cur_a    = last_a[idx];
  assign cur_b    = last_b[idx];
  assign cur_dir  = direction[idx];
  assign cur_pos  = position_count[idx];
  assign cur_snap = snapshot_count[idx];

  assign a_chg = (pin_a != cur_a);
  assign b_chg = (pin_b != cur_b);

  // A step goes forward when A != B, B step when A == B; both at once keep the count but set direction
  always_comb begin
    pos_next = cur_pos;
    dir_next = cur_dir;
    if (a_chg && b_chg) begin
      dir_next = (pin_a == pin_b);
    end else if (a_chg) begin
      dir_next = (pin_a != pin_b);
      pos_next = dir_next ? cur_pos + 1'b1 : cur_pos - 1'b1;
    end else if (b_chg) begin
      dir_next = (pin_a == pin_b);
      pos_next = dir_next ? cur_pos + 1'b1 : cur_pos - 1'b1;
    end
  end

  assign diff = cur_dir ? (cur_pos - cur_snap) : (cur_snap - cur_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        last_a[k]         <= 1'b0;
        last_b[k]         <= 1'b0;
        position_count[k] <= '0;
        direction[k]      <= 1'b0;
        snapshot_count[k] <= '0;
      end
    end else if (accept && ch_ok) begin
      if (mode == qdec_pkg::MODE_PINS) begin
        last_a[idx]         <= pin_a;
        last_b[idx]         <= pin_b;
        position_count[idx] <= pos_next;
        direction[idx]      <= dir_next;
      end else begin
        snapshot_count[idx] <= cur_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!ch_ok) begin
        st_tag  <= '0;
        st_diff <= '0;
      end else if (mode == qdec_pkg::MODE_PINS) begin
        st_tag.position    <= qdec_pkg::POS_BITS'(pos_next);
        st_tag.forward     <= dir_next;
        st_tag.speed_valid <= 1'b0;
        st_diff            <= '0;
      end else begin
        st_tag.position    <= qdec_pkg::POS_BITS'(cur_pos);
        st_tag.forward     <= cur_dir;
        st_tag.speed_valid <= 1'b1;
        st_diff            <= diff;
      end
    end
  end

endmodule

// ===== rtl/qdec_speed.sv =====
// Speed pipeline: count difference times scale, then saturate and sign.
// Depends on qdec_pkg.
module qdec_speed #(
  parameter int COUNT_BITS = qdec_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  st_valid,
  output logic                                  st_ready,
  input  qdec_pkg::qdec_tag_t                   st_tag,
  input  logic [COUNT_BITS-1:0]                 st_diff,
  input  logic [qdec_pkg::SCALE_BITS-1:0]       speed_scale,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output qdec_pkg::qdec_tag_t                   out_tag,
  output logic signed [qdec_pkg::SPEED_BITS-1:0] out_speed
);

  localparam int PW = COUNT_BITS + qdec_pkg::SCALE_BITS;

  logic                      mul_valid;
  logic                      mul_ready;
  qdec_pkg::qdec_tag_t       mul_tag;
  logic [PW-1:0]             prod;
  logic [63:0]               prod_w;
  logic [63:0]               mag;
  logic [qdec_pkg::SPEED_BITS-1:0] speed_next;

  assign mul_ready = !out_valid || out_ready;
  assign st_ready  = !mul_valid || mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (st_ready) begin
      mul_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_valid && st_ready) begin
      mul_tag <= st_tag;
      prod    <= PW'(st_diff) * PW'(speed_scale);
    end
  end

  assign prod_w = 64'(prod);

  always_comb begin
    if (mul_tag.forward) begin
      mag        = (prod_w > qdec_pkg::SPEED_POS_MAX) ? qdec_pkg::SPEED_POS_MAX : prod_w;
      speed_next = qdec_pkg::SPEED_BITS'(mag);
    end else begin
      mag        = (prod_w > qdec_pkg::SPEED_NEG_MAG) ? qdec_pkg::SPEED_NEG_MAG : prod_w;
      speed_next = qdec_pkg::SPEED_BITS'(64'd0 - mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mul_ready) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid && mul_ready) begin
      out_tag   <= mul_tag;
      out_speed <= speed_next;
    end
  end

endmodule

// ===== rtl/quadrature_decoder_with_speed_unit.sv =====
// Top level of the x4 quadrature decoder with speed measurement.
// Depends on qdec_pkg, qdec_track and qdec_speed.
//
// Request channel (s_*): s_tuser = {channel[2:1], mode[0]}, s_tdata = {pin_b[1], pin_a[0]}.
// A mode 0 request carries one channel's sampled A/B levels; edges step the
// channel's 16-bit wrapping position and set its direction. A mode 1 request
// returns the count moved since the previous measurement times speed_scale,
// as signed Q32.16 rad/s (saturated to 48 bits), and takes a new snapshot.
// Result channel (m_*): m_tdata = {speed_q16[64:17], moving_forward[16],
// position[15:0]}, m_tuser = speed_valid. One result per request, in order.
// Requests for a channel at or above CHANNELS return all-zero results.
// Config: APB register speed_scale at address 0. The user must write it only while idle;
// the block does not enforce this. Throughput: one request per cycle
// unless stalled by m_tready (below). Stages: state update, multiply, saturate/output.
// Per-channel state is updated at acceptance, so back-to-back requests to one
// channel see each other's effect without stalls.
// When m_tready is low, results back up in the three stages; s_tready drops
// only once all of them are full. Reset clears all channel state, speed_scale
// and the pipeline.
module quadrature_decoder_with_speed_unit #(
  parameter int CHANNELS   = qdec_pkg::CHANNELS_DEF,
  parameter int COUNT_BITS = qdec_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // APB configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [qdec_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // pin_a, pin_b, zero pad
  input  logic [2:0]                         s_tuser,  // mode, channel[1:0]
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [71:0]                        m_tdata,  // position, moving_forward, speed_q16, pad
  output logic [0:0]                         m_tuser   // speed_valid
);

  logic [qdec_pkg::SCALE_BITS-1:0]            speed_scale;
  logic                                       st_valid;
  logic                                       st_ready;
  qdec_pkg::qdec_tag_t                        st_tag;
  logic [COUNT_BITS-1:0]                      st_diff;
  qdec_pkg::qdec_tag_t                        out_tag;
  logic signed [qdec_pkg::SPEED_BITS-1:0]     out_speed;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == qdec_pkg::REG_SPEED_SCALE) begin
      speed_scale <= pwdata;
    end
  end

  assign prdata = (paddr[2] == qdec_pkg::REG_SPEED_SCALE) ? speed_scale : 32'd0;

  qdec_track #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_track (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .mode     (s_tuser[0]),
    .channel  (s_tuser[2:1]),
    .pin_a    (s_tdata[0]),
    .pin_b    (s_tdata[1]),
    .st_valid (st_valid),
    .st_ready (st_ready),
    .st_tag   (st_tag),
    .st_diff  (st_diff)
  );

  qdec_speed #(
    .COUNT_BITS (COUNT_BITS)
  ) u_speed (
    .clk         (clk),
    .rst         (rst),
    .st_valid    (st_valid),
    .st_ready    (st_ready),
    .st_tag      (st_tag),
    .st_diff     (st_diff),
    .speed_scale (speed_scale),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_tag     (out_tag),
    .out_speed   (out_speed)
  );

  assign m_tdata = {7'd0, out_speed, out_tag.forward, out_tag.position};
  assign m_tuser = out_tag.speed_valid;

  // position-only results never carry a speed
  a_no_speed_in_pin_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_tag.speed_valid) |-> (out_speed == '0))
    else $error("speed nonzero on a pin-sample result");

  // forward speed is never negative
  a_forward_sign: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_tag.speed_valid && out_tag.forward) |-> !out_speed[47])
    else $error("negative speed while moving forward");

  // backward speed is never positive
  a_backward_sign: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_tag.speed_valid && !out_tag.forward) |->
      (out_speed[47] || out_speed == '0))
    else $error("positive speed while moving backward");

  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!m_tvalid && !st_valid))
    else $error("pipeline holds data after reset");

endmodule

// ===== test/qdec_checker.sv =====
`timescale 1ns / 1ps
// Checker for the quadrature decoder with speed unit: snoops APB writes and both streams,
// predicts each result and compares it field by field. Depends on qdec_pkg.
module qdec_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // pin_a, pin_b, zero pad
  input  logic [2:0]  s_tuser,   // mode, channel[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // position, moving_forward, speed_q16, pad
  input  logic [0:0]  m_tuser,   // speed_valid
  output int          errors,
  output int          outstanding
);

  localparam int N_CH = qdec_pkg::CHANNELS_DEF;

  typedef struct packed {
    logic [15:0] position;
    logic        moving_forward;
    logic [47:0] speed_q16;
    logic        speed_valid;
  } qdec_result_t;

  logic        prev_a  [N_CH];
  logic        prev_b  [N_CH];
  logic        fwd_dir [N_CH];
  logic [15:0] count   [N_CH];
  logic [15:0] snap    [N_CH];
  logic [31:0] scale;

  qdec_result_t expected_results[$];
  qdec_result_t want, got;

  function automatic void move_count(int ch, logic fwd);
    fwd_dir[ch] = fwd;
    count[ch]   = fwd ? count[ch] + 16'd1 : count[ch] - 16'd1;
  endfunction

  // Applies one request to the shadow state and returns the result it produces.
  function automatic qdec_result_t decode_request(logic mode, logic [1:0] ch, logic a,
                                                  logic b);
    qdec_result_t r;
    logic [15:0]  diff;
    logic [63:0]  mag;
    r = '0;
    if (int'(ch) >= N_CH) return r;
    if (mode == qdec_pkg::MODE_PINS) begin
      if (a != prev_a[ch]) begin
        prev_a[ch] = a;
        move_count(ch, a != b);
      end
      if (b != prev_b[ch]) begin
        prev_b[ch] = b;
        move_count(ch, a == b);
      end
    end else begin
      diff = fwd_dir[ch] ? count[ch] - snap[ch] : snap[ch] - count[ch];
      mag  = 64'(diff) * 64'(scale);
      if (fwd_dir[ch]) begin
        if (mag > qdec_pkg::SPEED_POS_MAX) mag = qdec_pkg::SPEED_POS_MAX;
        r.speed_q16 = mag[47:0];
      end else begin
        if (mag > qdec_pkg::SPEED_NEG_MAG) mag = qdec_pkg::SPEED_NEG_MAG;
        r.speed_q16 = 48'(~mag + 64'd1);
      end
      r.speed_valid = 1'b1;
      snap[ch] = count[ch];
    end
    r.position       = count[ch];
    r.moving_forward = fwd_dir[ch];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      scale = '0;
      for (int k = 0; k < N_CH; k++) begin
        prev_a[k]  = 1'b0;
        prev_b[k]  = 1'b0;
        fwd_dir[k] = 1'b0;
        count[k]   = '0;
        snap[k]    = '0;
      end
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == qdec_pkg::REG_SPEED_SCALE)
        scale = pwdata;
      if (s_tvalid && s_tready)
        expected_results.push_back(decode_request(s_tuser[0], s_tuser[2:1], s_tdata[0],
                                                  s_tdata[1]));
      if (m_tvalid && m_tready) begin
        got.position       = m_tdata[15:0];
        got.moving_forward = m_tdata[16];
        got.speed_q16      = m_tdata[17 +: 48];
        got.speed_valid    = m_tuser[0];
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: position %0d", got.position);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.position != want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            errors++;
          end
          if (got.moving_forward != want.moving_forward) begin
            $error("moving_forward: expected %0d, got %0d", want.moving_forward,
                   got.moving_forward);
            errors++;
          end
          if (got.speed_q16 != want.speed_q16) begin
            $error("speed_q16: expected %0d, got %0d", $signed(want.speed_q16),
                   $signed(got.speed_q16));
            errors++;
          end
          if (got.speed_valid != want.speed_valid) begin
            $error("speed_valid: expected %0d, got %0d", want.speed_valid, got.speed_valid);
            errors++;
          end
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== test/tb_quadrature_decoder_with_speed_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for quadrature_decoder_with_speed_unit: clock, reset, APB writes and
// encoder request stimulus under several idle patterns. Depends on qdec_pkg and qdec_checker.
module tb_quadrature_decoder_with_speed_unit;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 100;
  localparam int N_PHASES       = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // pin_a, pin_b, zero pad
  logic [2:0]  s_tuser = '0;   // mode, channel[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // position, moving_forward, speed_q16, pad
  logic [0:0]  m_tuser;        // speed_valid

  int errors;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;

  // pin levels last sent per channel, and the way each channel is turning
  logic pa [4];
  logic pb [4];
  logic heading [4];

  quadrature_decoder_with_speed_unit DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  qdec_checker u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .errors, .outstanding
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic apb_write(input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {qdec_pkg::REG_SPEED_SCALE, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Leaves s_tvalid high after the handshake; the next call or end_burst decides.
  task automatic send_sample(input logic mode, input logic [1:0] ch, input logic a,
                             input logic b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {ch, mode};
    s_tdata  <= {6'b0, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic end_burst();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // One Gray-code step: forward is (a,b) -> (~b,a), backward is (a,b) -> (b,~a).
  task automatic step_channel(input logic [1:0] ch, input logic fwd);
    logic na, nb;
    na = fwd ? ~pb[ch] : pb[ch];
    nb = fwd ? pa[ch] : ~pa[ch];
    pa[ch] = na;
    pb[ch] = nb;
    send_sample(qdec_pkg::MODE_PINS, ch, na, nb);
  endtask

  task automatic measure(input logic [1:0] ch);
    send_sample(qdec_pkg::MODE_SPEED, ch, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic random_item();
    logic [1:0] ch;
    int r;
    ch = 2'($urandom_range(0, 3));
    r  = $urandom_range(0, 99);
    if (r < 12)
      measure(ch);
    else if (r < 20) begin
      // noise: arbitrary levels, often a double change or a skipped state
      pa[ch] = 1'($urandom_range(0, 1));
      pb[ch] = 1'($urandom_range(0, 1));
      send_sample(qdec_pkg::MODE_PINS, ch, pa[ch], pb[ch]);
    end else if (r < 25)
      send_sample(qdec_pkg::MODE_PINS, ch, pa[ch], pb[ch]);
    else begin
      if ($urandom_range(0, 99) < 15) heading[ch] = ~heading[ch];
      step_channel(ch, heading[ch]);
    end
  endtask

  initial begin
    logic [31:0] scales [N_PHASES];
    scales = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0006_487F,
               32'h0, 32'h8000_0000, 32'h0, 32'h0};
    for (int k = 0; k < 4; k++) begin
      pa[k] = 1'b0;
      pb[k] = 1'b0;
      heading[k] = 1'($urandom_range(0, 1));
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at full scale so that both saturation limits are reached
    apb_write(32'hFFFF_FFFF);
    measure(2'd0);                                  // nothing moved since reset
    repeat (4) step_channel(2'd0, 1'b1);
    measure(2'd0);
    repeat (3) step_channel(2'd1, 1'b0);            // count wraps below zero
    measure(2'd1);
    pa[2] = 1'b1; pb[2] = 1'b1;                     // both phases change at once
    send_sample(qdec_pkg::MODE_PINS, 2'd2, 1'b1, 1'b1);
    pa[2] = 1'b0; pb[2] = 1'b0;
    send_sample(qdec_pkg::MODE_PINS, 2'd2, 1'b0, 1'b0);
    send_sample(qdec_pkg::MODE_PINS, 2'd2, 1'b0, 1'b0);  // no change
    measure(2'd2);
    measure(2'd3);
    repeat (3) step_channel(2'd3, 1'b0);
    step_channel(2'd3, 1'b1);                       // forward over a near-full wrap
    measure(2'd3);
    repeat (3) step_channel(2'd0, 1'b1);
    step_channel(2'd0, 1'b0);                       // backward over a near-full wrap
    measure(2'd0);
    end_burst();
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      if (scales[p] == 32'h0 && p >= 4) scales[p] = $urandom;
      apb_write(scales[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
      end_burst();
      drain();
    end

    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qdec_pkg.sv
rtl/qdec_track.sv
rtl/qdec_speed.sv
rtl/quadrature_decoder_with_speed_unit.sv
test/qdec_checker.sv
test/tb_quadrature_decoder_with_speed_unit.sv
